// ----- rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent-assertion macros for the frame error injector checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property sampled on aclk, ignored while aresetn is low.
`define FBEI_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);

// Condition in one cycle implies a consequence in the next cycle.
`define FBEI_ASSERT_NEXT(label, cond, conseq, msg) \
    `FBEI_ASSERT(label, (cond) |=> (conseq), msg)

`endif

// ----- rtl/fbei_pkg.sv -----
// ----------------------------------------------------------------------------
// fbei_pkg
// Shared types and constants for the frame bit error injector.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package fbei_pkg;

    // Frame buffer capacity default (bytes)
    localparam int FRAME_BYTES_DEF = 256;

    // Port widths
    localparam int S_TDATA_W  = 88;
    localparam int S_TUSER_W  = 3;
    localparam int M_TDATA_W  = 16;
    localparam int CFG_ADDR_W = 1;
    localparam int CFG_DATA_W = 32;

    // Field widths
    localparam int KIND_W   = 3;
    localparam int BYTE_W   = 8;
    localparam int BIT_W    = 16;
    localparam int PROB_W   = 33;
    localparam int FLEN_W   = 9;
    localparam int LEN_W    = 14;   // holds min(frame_length, capacity) up to 8192
    localparam int GEN_W    = 32;
    localparam int DIVSR_W  = 17;   // bit count of the frame, up to 65536
    localparam int DIV_STEPS = 32;
    localparam int DIV_CNT_W = 5;

    // Generator constants
    localparam logic [GEN_W-1:0] LCG_MUL = 32'd1664525;
    localparam logic [GEN_W-1:0] LCG_ADD = 32'd1013904223;

    // Item kinds
    localparam logic [KIND_W-1:0] KIND_WRITE = 3'd0;
    localparam logic [KIND_W-1:0] KIND_READ  = 3'd1;
    localparam logic [KIND_W-1:0] KIND_FLIP  = 3'd2;
    localparam logic [KIND_W-1:0] KIND_BURST = 3'd3;
    localparam logic [KIND_W-1:0] KIND_RAND  = 3'd4;
    localparam logic [KIND_W-1:0] KIND_PROB  = 3'd5;

    // Configuration register indexes
    localparam logic [CFG_ADDR_W-1:0] REG_FRAME_LENGTH = 1'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_RNG_SEED     = 1'd1;

    // Controller -> datapath
    typedef struct packed {
        logic load_item;
        logic res_clear;
        logic set_ok;
        logic set_dec_one;
        logic dec_cmp;
        logic cap_rd;
        logic ram_wr_byte;
        logic ram_rd_byte;
        logic gen_adv;
        logic div_start;
        logic div_step;
        logic walk_bit;
        logic walk_burst;
        logic walk_rand;
        logic rmw_rd;
        logic rmw_wr;
        logic out_load;
    } fbei_cmd_t;

    // Datapath -> controller
    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic byte_ok;
        logic bit_ok;
        logic burst_ok;
        logic frame_empty;
        logic prob_zero;
        logic prob_one;
        logic div_last;
        logic walk_last;
    } fbei_sts_t;

endpackage

// ----- rtl/fbei_ram.sv -----
// ----------------------------------------------------------------------------
// fbei_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fbei_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- rtl/fbei_ctrl.sv -----
// ----------------------------------------------------------------------------
// fbei_ctrl
// Item sequencer: decodes the kind, steps divider and byte walk, owns the
// output valid flag.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fbei_ctrl
    import fbei_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_tvalid,
    output logic      s_tready,
    output logic      m_tvalid,
    input  logic      m_tready,
    input  fbei_sts_t sts,
    output fbei_cmd_t cmd
);

    localparam logic [3:0] ST_IDLE    = 4'd0;
    localparam logic [3:0] ST_DECODE  = 4'd1;
    localparam logic [3:0] ST_RD_WAIT = 4'd2;
    localparam logic [3:0] ST_RMW_RD  = 4'd3;
    localparam logic [3:0] ST_RMW_WR  = 4'd4;
    localparam logic [3:0] ST_DIV     = 4'd5;
    localparam logic [3:0] ST_DIV_END = 4'd6;
    localparam logic [3:0] ST_PROB    = 4'd7;
    localparam logic [3:0] ST_FINISH  = 4'd8;

    logic [3:0] state_reg, state_next;
    logic       out_valid_reg, out_valid_next;

    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.load_item = 1'b1;
                    state_next    = ST_DECODE;
                end
            end
            ST_DECODE: begin
                cmd.res_clear = 1'b1;
                state_next    = ST_FINISH;
                case (sts.kind)
                    KIND_WRITE: begin
                        if (sts.byte_ok) begin
                            cmd.ram_wr_byte = 1'b1;
                            cmd.set_ok      = 1'b1;
                        end
                    end
                    KIND_READ: begin
                        if (sts.byte_ok) begin
                            cmd.ram_rd_byte = 1'b1;
                            cmd.set_ok      = 1'b1;
                            state_next      = ST_RD_WAIT;
                        end
                    end
                    KIND_FLIP: begin
                        if (sts.bit_ok) begin
                            cmd.walk_bit = 1'b1;
                            cmd.set_ok   = 1'b1;
                            state_next   = ST_RMW_RD;
                        end
                    end
                    KIND_BURST: begin
                        if (sts.burst_ok) begin
                            cmd.walk_burst = 1'b1;
                            cmd.set_ok     = 1'b1;
                            state_next     = ST_RMW_RD;
                        end
                    end
                    KIND_RAND: begin
                        if (!sts.frame_empty) begin
                            cmd.gen_adv   = 1'b1;
                            cmd.div_start = 1'b1;
                            cmd.set_ok    = 1'b1;
                            state_next    = ST_DIV;
                        end
                    end
                    KIND_PROB: begin
                        cmd.set_ok = 1'b1;
                        if (sts.prob_one) begin
                            cmd.set_dec_one = 1'b1;
                        end else if (!sts.prob_zero) begin
                            cmd.gen_adv = 1'b1;
                            state_next  = ST_PROB;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            ST_RD_WAIT: begin
                cmd.cap_rd = 1'b1;
                state_next = ST_FINISH;
            end
            ST_RMW_RD: begin
                cmd.rmw_rd = 1'b1;
                state_next = ST_RMW_WR;
            end
            ST_RMW_WR: begin
                cmd.rmw_wr = 1'b1;
                state_next = sts.walk_last ? ST_FINISH : ST_RMW_RD;
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                if (sts.div_last) begin
                    state_next = ST_DIV_END;
                end
            end
            ST_DIV_END: begin
                cmd.walk_rand = 1'b1;
                state_next    = ST_RMW_RD;
            end
            ST_PROB: begin
                cmd.dec_cmp = 1'b1;
                state_next  = ST_FINISH;
            end
            ST_FINISH: begin
                // wait for the output register to be free or being emptied
                if (!out_valid_reg || m_tready) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        if (cmd.out_load) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;

endmodule

// ----- rtl/fbei_dp.sv -----
// ----------------------------------------------------------------------------
// fbei_dp
// Datapath: item latch, config registers, LCG, radix-2 remainder unit,
// byte-walk read-modify-write on the frame RAM, result and output registers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fbei_dp
    import fbei_pkg::*;
#(
    parameter int FRAME_BYTES = FRAME_BYTES_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wr_data,
    input  logic [KIND_W-1:0]     kind,
    input  logic [BYTE_W-1:0]     byte_addr,
    input  logic [BYTE_W-1:0]     byte_value,
    input  logic [BIT_W-1:0]      bit_pos,
    input  logic [BIT_W-1:0]      burst_len,
    input  logic [PROB_W-1:0]     probability,
    input  fbei_cmd_t             cmd,
    output fbei_sts_t             sts,
    output logic                  ok,
    output logic [BYTE_W-1:0]     read_data,
    output logic                  decision
);

    localparam int ADDR_W = (FRAME_BYTES > 1) ? $clog2(FRAME_BYTES) : 1;

    // latched item
    logic [KIND_W-1:0] kind_reg;
    logic [BYTE_W-1:0] bidx_reg, bval_reg;
    logic [BIT_W-1:0]  bit_reg, blen_reg;
    logic [PROB_W-1:0] prob_reg;

    // config and generator
    logic [FLEN_W-1:0] flen_reg;
    logic [GEN_W-1:0]  gen_reg;
    logic [GEN_W-1:0]  gen_next;

    // remainder unit
    logic [GEN_W-1:0]     dvd_reg;
    logic [DIVSR_W-1:0]   rem_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [DIVSR_W:0]     div_shift, div_trial;
    logic [DIVSR_W-1:0]   divisor;

    // byte walk
    logic [BIT_W-1:0] cur_reg, last_reg;
    logic [BYTE_W-1:0] flip_mask;

    // result and output
    logic              res_ok_reg, res_dec_reg;
    logic [BYTE_W-1:0] res_rd_reg;
    logic              out_ok_reg, out_dec_reg;
    logic [BYTE_W-1:0] out_rd_reg;

    // checks
    logic [LEN_W-1:0]   flen_ext, valid_bytes;
    logic [DIVSR_W-1:0] burst_last;
    logic [12:0]        item_byte, cur_byte;

    // ram
    logic              ram_we, ram_re;
    logic [ADDR_W-1:0] ram_waddr, ram_raddr, item_addr, cur_addr;
    logic [BYTE_W-1:0] ram_wdata, ram_rdata;

    assign flen_ext    = LEN_W'(flen_reg);
    assign valid_bytes = (flen_ext > LEN_W'(FRAME_BYTES)) ? LEN_W'(FRAME_BYTES) : flen_ext;
    assign burst_last  = DIVSR_W'(bit_reg) + DIVSR_W'(blen_reg) - DIVSR_W'(1);
    assign divisor     = {valid_bytes, 3'b000};

    assign sts.kind        = kind_reg;
    assign sts.byte_ok     = ({8'd0, bidx_reg} < 16'(FRAME_BYTES));
    assign sts.bit_ok      = ({1'b0, bit_reg[15:3]} < valid_bytes);
    assign sts.burst_ok    = (blen_reg != '0) && (burst_last[16:3] < valid_bytes);
    assign sts.frame_empty = (valid_bytes == '0);
    assign sts.prob_zero   = (prob_reg == '0);
    assign sts.prob_one    = prob_reg[PROB_W-1];
    assign sts.div_last    = (cnt_reg == DIV_CNT_W'(DIV_STEPS - 1));
    assign sts.walk_last   = (cur_reg[15:3] == last_reg[15:3]);

    assign gen_next = GEN_W'(gen_reg * LCG_MUL) + LCG_ADD;

    assign div_shift = {rem_reg, dvd_reg[GEN_W-1]};
    assign div_trial = div_shift - {1'b0, divisor};

    // MSB-first: bits cur..last of this byte, clipped at the byte edge
    assign flip_mask = (8'hFF >> cur_reg[2:0]) &
                       (sts.walk_last ? (8'hFF << (3'd7 - last_reg[2:0])) : 8'hFF);

    assign item_byte = {5'd0, bidx_reg};
    assign cur_byte  = cur_reg[15:3];
    assign item_addr = item_byte[ADDR_W-1:0];
    assign cur_addr  = cur_byte[ADDR_W-1:0];

    assign ram_we    = cmd.ram_wr_byte | cmd.rmw_wr;
    assign ram_waddr = cmd.ram_wr_byte ? item_addr : cur_addr;
    assign ram_wdata = cmd.ram_wr_byte ? bval_reg : (ram_rdata ^ flip_mask);
    assign ram_re    = cmd.ram_rd_byte | cmd.rmw_rd;
    assign ram_raddr = cmd.ram_rd_byte ? item_addr : cur_addr;

    fbei_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (FRAME_BYTES)
    ) u_frame_ram (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_en   (ram_re),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    // config and generator
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            flen_reg <= '0;
            gen_reg  <= '0;
        end else begin
            if (cfg_wr_en && cfg_addr == REG_FRAME_LENGTH) begin
                flen_reg <= cfg_wr_data[FLEN_W-1:0];
            end
            if (cfg_wr_en && cfg_addr == REG_RNG_SEED) begin
                gen_reg <= cfg_wr_data[GEN_W-1:0];
            end else if (cmd.gen_adv) begin
                gen_reg <= gen_next;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (cmd.load_item) begin
            kind_reg <= kind;
            bidx_reg <= byte_addr;
            bval_reg <= byte_value;
            bit_reg  <= bit_pos;
            blen_reg <= burst_len;
            prob_reg <= probability;
        end

        if (cmd.div_start) begin
            dvd_reg <= gen_next;
            rem_reg <= '0;
            cnt_reg <= '0;
        end else if (cmd.div_step) begin
            dvd_reg <= {dvd_reg[GEN_W-2:0], 1'b0};
            rem_reg <= div_trial[DIVSR_W] ? div_shift[DIVSR_W-1:0] : div_trial[DIVSR_W-1:0];
            cnt_reg <= cnt_reg + DIV_CNT_W'(1);
        end

        if (cmd.walk_bit) begin
            cur_reg  <= bit_reg;
            last_reg <= bit_reg;
        end else if (cmd.walk_burst) begin
            cur_reg  <= bit_reg;
            last_reg <= burst_last[BIT_W-1:0];
        end else if (cmd.walk_rand) begin
            cur_reg  <= rem_reg[BIT_W-1:0];
            last_reg <= rem_reg[BIT_W-1:0];
        end else if (cmd.rmw_wr) begin
            cur_reg <= {cur_reg[15:3] + 13'd1, 3'b000};
        end

        if (cmd.res_clear) begin
            res_ok_reg  <= cmd.set_ok;
            res_dec_reg <= cmd.set_dec_one;
            res_rd_reg  <= '0;
        end else begin
            if (cmd.dec_cmp) begin
                res_dec_reg <= (gen_reg < prob_reg[GEN_W-1:0]);
            end
            if (cmd.cap_rd) begin
                res_rd_reg <= ram_rdata;
            end
        end

        if (cmd.out_load) begin
            out_ok_reg  <= res_ok_reg;
            out_dec_reg <= res_dec_reg;
            out_rd_reg  <= res_rd_reg;
        end
    end

    assign ok        = out_ok_reg;
    assign read_data = out_rd_reg;
    assign decision  = out_dec_reg;

endmodule

// ----- rtl/frame_bit_error_injector.sv -----
// ----------------------------------------------------------------------------
// frame_bit_error_injector
// Frame buffer with byte access, single/burst/random bit flips and an LCG
// driven probability draw.
// ----------------------------------------------------------------------------
//  Channel   Dir  Handshake           Contents
//  s_        in   s_tvalid/s_tready   tuser: kind; tdata: item fields
//  m_        out  m_tvalid/m_tready   tdata: ok, read_data, decision
//  cfg_      in   cfg_wr_en           0 frame_length, 1 rng_seed
//
//  One item at a time. Steps per item, from its accept to the earliest next accept:
//  write and read one frame RAM access, probability at most one generator
//  draw, single flip one read-modify-write, burst one read-modify-write per byte
//  touched, random flip 32 steps of the radix-2 remainder unit plus one
//  read-modify-write on the single-port-per-direction frame RAM.
//  The result sits in an output register, so the next transaction is taken
//  while a finished one waits; processing stalls only when it finishes again.
//  Reset (aresetn low, synchronous) clears control, frame_length and the
//  generator. Frame contents are undefined until written.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module frame_bit_error_injector
    import fbei_pkg::*;
#(
    parameter int FRAME_BYTES = FRAME_BYTES_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // input channel
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,   // byte_addr, byte_value, bit_pos,
                                             // burst_len, probability, zero pad
    input  logic [S_TUSER_W-1:0]  s_tuser,   // kind
    // result channel
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata,   // ok, read_data, decision, zero pad
    // configuration
    input  logic                  cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wr_data
);

    fbei_cmd_t         cmd;
    fbei_sts_t         sts;
    logic              ok, decision;
    logic [BYTE_W-1:0] read_data;

    // Sequencer: takes a transaction in idle, walks the kind's steps
    fbei_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // Datapath: field unpack happens right at the port
    fbei_dp #(
        .FRAME_BYTES (FRAME_BYTES)
    ) u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wr_data (cfg_wr_data),
        .kind        (s_tuser[KIND_W-1:0]),
        .byte_addr   (s_tdata[7:0]),
        .byte_value  (s_tdata[15:8]),
        .bit_pos     (s_tdata[31:16]),
        .burst_len   (s_tdata[47:32]),
        .probability (s_tdata[80:48]),
        .cmd         (cmd),
        .sts         (sts),
        .ok          (ok),
        .read_data   (read_data),
        .decision    (decision)
    );

    assign m_tdata = {6'd0, decision, read_data, ok};

endmodule

// ----- rtl/fbei_chk.sv -----
// ----------------------------------------------------------------------------
// fbei_chk
// Port-level checker for frame_bit_error_injector, attached by bind.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module fbei_chk
    import fbei_pkg::*;
(
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_tvalid,
    input logic                 s_tready,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata
);

    logic              res_ok, res_dec;
    logic [BYTE_W-1:0] res_rd;

    assign res_ok  = m_tdata[0];
    assign res_rd  = m_tdata[8:1];
    assign res_dec = m_tdata[9];

    `FBEI_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid, "result dropped")
    `FBEI_ASSERT_NEXT(a_out_stable, m_tvalid && !m_tready, $stable(m_tdata), "result changed")
    `FBEI_ASSERT_NEXT(a_one_in_flight, s_tvalid && s_tready, !s_tready, "taken while busy")
    `FBEI_ASSERT(a_ok_implied, m_tvalid && (res_dec || res_rd != '0) |-> res_ok, "data without ok")
    `FBEI_ASSERT(a_new_result_busy, $rose(m_tvalid) |-> !$past(s_tready), "result without work")

endmodule

bind frame_bit_error_injector fbei_chk u_fbei_chk (.*);
